>>> design/eik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eik_pkg;

  localparam int TW = 20;   // travel time, Q8.12
  localparam int SW = 16;   // speed / spacing weight, Q8.8
  localparam int QW = 18;   // quadratic coefficient
  localparam int LW = 40;   // linear coefficient (magnitude of -b)
  localparam int HW = 39;   // half of the linear coefficient
  localparam int CW = 58;   // constant coefficient

  localparam logic [TW-1:0] TMAX = '1;

  typedef enum logic [1:0] {
    ST_ROOT     = 2'd0,
    ST_FALLBACK = 2'd1,
    ST_NOFROZEN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SPACING0 = 2'd0,
    REG_SPACING1 = 2'd1,
    REG_SPACING2 = 2'd2,
    REG_FALLBACK = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SW-1:0] spacing0;
    logic [SW-1:0] spacing1;
    logic [SW-1:0] spacing2;
  } spacing_t;

  // one closed point waiting to be solved
  typedef struct packed {
    logic [QW-1:0] quad;
    logic [HW-1:0] half_lin;
    logic [CW-1:0] cnst;
    logic [TW-1:0] small_t;
    logic [SW-1:0] speed;
  } solve_req_t;

endpackage

`default_nettype wire

>>> design/eik_front.sv
`timescale 1ns / 1ps
`default_nettype none

module eik_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [eik_pkg::TW-1:0]   minus_time,
  input  wire                      minus_ok,
  input  wire  [eik_pkg::TW-1:0]   plus_time,
  input  wire                      plus_ok,
  input  wire  [eik_pkg::SW-1:0]   speed,
  input  wire                      last_axis,
  input  eik_pkg::spacing_t        spacing,
  output eik_pkg::solve_req_t      req,
  output logic                     req_push,
  input  wire                      req_full
);
  import eik_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_PUSH} fstate_t;

  fstate_t       state;
  logic [1:0]    axis_count;
  logic [QW-1:0] quad;
  logic [LW-1:0] lin;
  logic [CW-1:0] cnst;
  logic [TW-1:0] small_t;

  logic [TW-1:0] v;
  logic [SW-1:0] w;
  logic          ok;
  logic          last;
  logic [SW-1:0] speed_r;
  logic [35:0]   wv;

  logic [TW-1:0] v_sel;
  logic [SW-1:0] w_sel;
  logic [35:0]   wv_next;
  logic [55:0]   wvv;
  logic          accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == F_IDLE);
  assign req_push = (state == F_PUSH) && !req_full;

  // smaller usable neighbor
  always_comb begin
    if (minus_ok && plus_ok) begin
      v_sel = (minus_time < plus_time) ? minus_time : plus_time;
    end else if (minus_ok) begin
      v_sel = minus_time;
    end else begin
      v_sel = plus_time;
    end
  end

  always_comb begin
    unique case (axis_count)
      2'd0:    w_sel = spacing.spacing0;
      2'd1:    w_sel = spacing.spacing1;
      default: w_sel = spacing.spacing2;
    endcase
  end

  assign wv_next = w * v;
  assign wvv     = wv * v;

  assign req.quad     = quad;
  assign req.half_lin = lin[LW-1:1];
  assign req.cnst     = cnst;
  assign req.small_t  = small_t;
  assign req.speed    = speed_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      axis_count <= '0;
      quad       <= '0;
      lin        <= '0;
      cnst       <= '0;
      small_t    <= TMAX;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_MUL1;
          end
        end
        F_MUL1: begin
          state <= F_MUL2;
        end
        F_MUL2: begin
          if (ok) begin
            quad <= quad + {2'b0, w};
            lin  <= lin + {3'b0, wv, 1'b0};
            cnst <= cnst + {2'b0, wvv};
            if (v < small_t) begin
              small_t <= v;
            end
          end
          if (axis_count != 2'd3) begin
            axis_count <= axis_count + 2'd1;
          end
          state <= last ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!req_full) begin
            axis_count <= '0;
            quad       <= '0;
            lin        <= '0;
            cnst       <= '0;
            small_t    <= TMAX;
            state      <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      v       <= v_sel;
      w       <= w_sel;
      ok      <= minus_ok || plus_ok;
      last    <= last_axis;
      speed_r <= speed;
    end
    if (state == F_MUL1) begin
      wv <= wv_next;
    end
  end

endmodule

`default_nettype wire

>>> design/eik_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module eik_fifo (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  eik_pkg::solve_req_t  din,
  output logic                 full,
  input  wire                  pop,
  output eik_pkg::solve_req_t  dout,
  output logic                 empty
);
  import eik_pkg::*;

  solve_req_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> design/eik_back.sv
`timescale 1ns / 1ps
`default_nettype none

module eik_back #(
  parameter int DIMS = 2
) (
  input  wire                      clk,
  input  wire                      rst,
  input  eik_pkg::solve_req_t      req,
  input  wire                      req_empty,
  output logic                     req_pop,
  input  wire  [eik_pkg::TW-1:0]   fallback_step,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [eik_pkg::TW-1:0]   travel_time,
  output eik_pkg::status_t         status
);
  import eik_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_SETUP, B_MUL_HH, B_MUL_AC, B_DIV_S, B_CHECK, B_SQRT, B_DIV_T, B_OUT
  } bstate_t;

  bstate_t       state;
  logic [6:0]    cnt;
  logic [QW-1:0] a;
  logic [HW-1:0] h;
  logic [CW-1:0] c;
  logic [TW-1:0] small_t;
  logic [SW-1:0] spd;
  logic [31:0]   s2;
  logic [79:0]   mcand;
  logic [HW-1:0] mplier;
  logic [79:0]   acc;
  logic [79:0]   p;
  logic [79:0]   q;
  logic [79:0]   dvd;
  logic [41:0]   rem;
  logic [65:0]   quo;
  logic [39:0]   root;

  logic [79:0]   acc_add;
  logic [SW-1:0] spd_nz;
  logic [33:0]   ds_sh, ds_diff;
  logic          ds_bit;
  logic [32:0]   ds_rem;
  logic [18:0]   dt_sh;
  logic [19:0]   dt_diff;
  logic          dt_bit;
  logic [17:0]   dt_rem;
  logic [43:0]   sq_sh, sq_trial, sq_diff;
  logic          sq_ge;
  logic [39:0]   root_nx;
  logic [40:0]   t_num;
  logic [TW:0]   fb_sum;
  logic [TW-1:0] u_small;

  assign req_pop = (state == B_IDLE) && !req_empty;

  assign acc_add = mplier[0] ? acc + mcand : acc;
  assign spd_nz  = (spd == '0) ? SW'(1) : spd;

  // restoring divide step: slowness term
  assign ds_sh   = {rem[32:0], dvd[79]};
  assign ds_diff = ds_sh - {2'b0, s2};
  assign ds_bit  = !ds_diff[33];
  assign ds_rem  = ds_bit ? ds_diff[32:0] : ds_sh[32:0];

  // restoring divide step: final time
  assign dt_sh   = {rem[17:0], dvd[79]};
  assign dt_diff = {1'b0, dt_sh} - {2'b0, a};
  assign dt_bit  = !dt_diff[19];
  assign dt_rem  = dt_bit ? dt_diff[17:0] : dt_sh[17:0];

  // square root, two bits of radicand a step
  assign sq_sh    = {rem, dvd[79:78]};
  assign sq_trial = {2'b0, root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;
  assign root_nx  = {root[38:0], sq_ge};

  assign t_num   = {2'b0, h} + {1'b0, root};
  assign u_small = (DIMS == 2) ? small_t : '0;
  assign fb_sum  = {1'b0, u_small} + {1'b0, fallback_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!req_empty) begin
            a       <= req.quad;
            h       <= req.half_lin;
            c       <= req.cnst;
            small_t <= req.small_t;
            spd     <= req.speed;
            state   <= B_SETUP;
          end
        end
        B_SETUP: begin
          if (a == '0) begin
            travel_time <= TMAX;
            status      <= ST_NOFROZEN;
            out_valid   <= 1'b1;
            state       <= B_OUT;
          end else begin
            s2     <= spd_nz * spd_nz;
            mcand  <= {41'b0, h};
            mplier <= h;
            acc    <= '0;
            cnt    <= 7'(HW);
            state  <= B_MUL_HH;
          end
        end
        B_MUL_HH: begin
          acc    <= acc_add;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            p      <= acc_add;
            mcand  <= {22'b0, c};
            mplier <= {21'b0, a};
            acc    <= '0;
            cnt    <= 7'(QW);
            state  <= B_MUL_AC;
          end
        end
        B_MUL_AC: begin
          acc    <= acc_add;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            q     <= acc_add;
            dvd   <= {a, 62'b0};    // a * 2^48, top aligned in the 80-bit dvd
            rem   <= '0;
            quo   <= '0;
            cnt   <= 7'd66;
            state <= B_DIV_S;
          end
        end
        B_DIV_S: begin
          rem   <= {9'b0, ds_rem};
          quo   <= {quo[64:0], ds_bit};
          dvd   <= dvd << 1;
          cnt   <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            p     <= p + {14'b0, quo[64:0], ds_bit};
            state <= B_CHECK;
          end
        end
        B_CHECK: begin
          if (p < q) begin
            travel_time <= fb_sum[TW] ? TMAX : fb_sum[TW-1:0];
            status      <= ST_FALLBACK;
            out_valid   <= 1'b1;
            state       <= B_OUT;
          end else begin
            dvd   <= p - q;
            rem   <= '0;
            root  <= '0;
            cnt   <= 7'd40;
            state <= B_SQRT;
          end
        end
        B_SQRT: begin
          rem  <= sq_ge ? sq_diff[41:0] : sq_sh[41:0];
          root <= root_nx;
          dvd  <= dvd << 2;
          cnt  <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= B_DIV_T;
            cnt   <= 7'd41;
            quo   <= '0;
            rem   <= '0;
          end
        end
        B_DIV_T: begin
          if (cnt == 7'd41) begin
            // first step loads the numerator; root is final here
            dvd <= {t_num, 39'b0};
            cnt <= cnt - 7'd1;
          end else begin
            rem <= {24'b0, dt_rem};
            quo <= {quo[64:0], dt_bit};
            dvd <= dvd << 1;
            cnt <= cnt - 7'd1;
            if (cnt == 7'd0) begin
              travel_time <= (|quo[39:19]) ? TMAX : {quo[18:0], dt_bit};
              status      <= ST_ROOT;
              out_valid   <= 1'b1;
              state       <= B_OUT;
            end
          end
        end
        B_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_nofrozen_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NOFROZEN) |-> travel_time == TMAX)
    else $error("no-frozen result not saturated");
  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == B_OUT)
    else $error("result shown outside output state");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    req_pop |=> state == B_SETUP)
    else $error("pop did not start a solve");

endmodule

`default_nettype wire

>>> design/eikonal_update_first_order.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Request                       Payload
// s_*       in   one axis of one grid point    tdata: minus_time[19:0] minus_ok[20]
//                                              plus_time[40:21] plus_ok[41]
//                                              speed[57:42]; tlast: last_axis
// m_*       out  updated point time            tdata: travel_time[19:0]; tuser: status
// cfg_*     in   register write                cfg_addr 0..2 spacing, 3 fallback step
//
// Front end: each axis request passes F_IDLE, F_MUL1, F_MUL2; the last axis adds F_PUSH,
// which queues the point. Solver: bit-serial 39-step and 18-step multiplies, 66-step
// slowness divide, 40-step square root, 41-step final divide; it sets the rate.
// A two-entry queue lets the front gather the next point while the solver works.
// rst is synchronous: clears accumulators, queue and solver, restores register defaults.
// The result register holds until m_tready; the solver stalls there, the front runs on.

module eikonal_update_first_order #(
  parameter int DIMS = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // minus_time, minus_ok, plus_time, plus_ok, speed, pad
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // travel_time, pad
  output logic [1:0]  m_tuser,   // status
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [19:0] cfg_data
);
  import eik_pkg::*;

  spacing_t      spacing;
  logic [TW-1:0] fallback_step;

  solve_req_t    req_in;
  solve_req_t    req_out;
  logic          req_push;
  logic          req_pop;
  logic          req_full;
  logic          req_empty;

  logic [TW-1:0] travel_time;
  status_t       status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing.spacing0 <= SW'(256);
      spacing.spacing1 <= SW'(256);
      spacing.spacing2 <= SW'(256);
      fallback_step    <= TW'(4096);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_SPACING0: spacing.spacing0 <= cfg_data[SW-1:0];
        REG_SPACING1: spacing.spacing1 <= cfg_data[SW-1:0];
        REG_SPACING2: spacing.spacing2 <= cfg_data[SW-1:0];
        REG_FALLBACK: fallback_step    <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // front: per-axis coefficient accumulation
  eik_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .minus_time (s_tdata[19:0]),
    .minus_ok   (s_tdata[20]),
    .plus_time  (s_tdata[40:21]),
    .plus_ok    (s_tdata[41]),
    .speed      (s_tdata[57:42]),
    .last_axis  (s_tlast),
    .spacing    (spacing),
    .req        (req_in),
    .req_push   (req_push),
    .req_full   (req_full)
  );

  eik_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (req_push),
    .din   (req_in),
    .full  (req_full),
    .pop   (req_pop),
    .dout  (req_out),
    .empty (req_empty)
  );

  // back: quadratic solve
  eik_back #(
    .DIMS (DIMS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .req           (req_out),
    .req_empty     (req_empty),
    .req_pop       (req_pop),
    .fallback_step (fallback_step),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .travel_time   (travel_time),
    .status        (status)
  );

  assign m_tdata = {4'b0, travel_time};
  assign m_tuser = status;

endmodule

`default_nettype wire

>>> verif/eik_update_checker.sv
`timescale 1ns / 1ps

// Watches the axis and result channels, predicts each point's time and status.
module eik_update_checker
  import eik_pkg::*;
#(
  parameter int DIMS = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [63:0] s_tdata,
  input  wire         s_tlast,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [23:0] m_tdata,
  input  wire  [1:0]  m_tuser,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [19:0] cfg_data,
  output int          fail_count,
  output int          pending_points
);

  typedef struct {
    logic [TW-1:0] tt;
    status_t       st;
  } point_result_t;

  point_result_t expected_points[$];

  logic [SW-1:0] weight[3];
  logic [TW-1:0] step;
  logic [1:0]    axis_no;
  logic [QW-1:0] acc_quad;
  logic [LW-1:0] acc_lin;
  logic [CW-1:0] acc_const;
  logic [TW-1:0] axis_min;

  assign pending_points = expected_points.size();

  function automatic logic [63:0] isqrt128(input logic [127:0] d);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= d) r = c;
    end
    return r;
  endfunction

  // fold one axis request; pushes the expected result when a point closes
  task automatic fold_axis(input logic [63:0] d, input logic lastf);
    logic [TW-1:0]  tm, tp, v;
    logic           okm, okp;
    logic [SW-1:0]  spd, w;
    logic [127:0]   h, a, num, s2, slow, p, q;
    logic [127:0]   tt;
    logic [TW:0]    fsum;
    point_result_t  r;
    tm  = d[19:0];
    okm = d[20];
    tp  = d[40:21];
    okp = d[41];
    spd = d[57:42];
    w   = weight[(axis_no < 2) ? axis_no : 2];
    if (okm || okp) begin
      if (okm && okp) v = (tm < tp) ? tm : tp;
      else v = okm ? tm : tp;
      acc_quad  = acc_quad + QW'(w);
      acc_lin   = acc_lin + LW'(2 * 64'(w) * 64'(v));
      acc_const = acc_const + CW'(64'(w) * 64'(v) * 64'(v));
      if (v < axis_min) axis_min = v;
    end
    if (axis_no < 3) axis_no++;
    if (!lastf) return;
    if (acc_quad == 0) begin
      r.tt = TMAX;
      r.st = ST_NOFROZEN;
    end else begin
      a    = 128'(acc_quad);
      h    = 128'(acc_lin >> 1);
      s2   = (spd == 0) ? 128'd1 : 128'(spd) * 128'(spd);
      num  = a << 48;
      slow = num / s2;
      p    = h * h + slow;
      q    = a * 128'(acc_const);
      if (p < q) begin
        fsum = ((DIMS == 2) ? {1'b0, axis_min} : '0) + {1'b0, step};
        r.tt = fsum[TW] ? TMAX : fsum[TW-1:0];
        r.st = ST_FALLBACK;
      end else begin
        tt   = (h + 128'(isqrt128(p - q))) / a;
        r.tt = (tt > 128'(TMAX)) ? TMAX : tt[TW-1:0];
        r.st = ST_ROOT;
      end
    end
    expected_points.push_back(r);
    axis_no   = '0;
    acc_quad  = '0;
    acc_lin   = '0;
    acc_const = '0;
    axis_min  = TMAX;
  endtask

  always @(posedge clk) begin
    point_result_t e;
    if (rst) begin
      weight    = '{16'd256, 16'd256, 16'd256};
      step      = 20'd4096;
      axis_no   = '0;
      acc_quad  = '0;
      acc_lin   = '0;
      acc_const = '0;
      axis_min  = TMAX;
      fail_count = 0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_FALLBACK) step = cfg_data;
        else weight[cfg_addr] = cfg_data[SW-1:0];
      end
      if (s_tvalid && s_tready) fold_axis(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: travel_time %0h status %0d", m_tdata[19:0], m_tuser);
          fail_count++;
        end else begin
          e = expected_points.pop_front();
          if (m_tdata[19:0] !== e.tt) begin
            $error("travel_time: expected %0h actual %0h", e.tt, m_tdata[19:0]);
            fail_count++;
          end
          if (m_tuser !== e.st) begin
            $error("status: expected %0d actual %0d", e.st, m_tuser);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_eikonal_update_first_order.sv
`timescale 1ns / 1ps

// Stimulus and verdict; the checker does all prediction.
module tb_eikonal_update_first_order;
  import eik_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_SPACING0;
  logic [19:0] cfg_data = '0;
  int          fail_count;
  int          pending_points;

  always #10 clk = ~clk;

  eikonal_update_first_order #(.DIMS(2)) i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_we, .cfg_addr, .cfg_data
  );

  eik_update_checker #(.DIMS(2)) i_checker (.*);

  // result side: random backpressure, mostly short, sometimes long, sometimes none
  int stall_mode = 0;
  int hold_cycles = 0;
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles = 0;
      m_tready <= 1'b0;
    end else if (stall_mode == 0) begin
      m_tready <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_cycles = $urandom_range(20, 150);
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // gap before a request: mostly short, a few long
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 300) : $urandom_range(0, 2);
    if (n != 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one axis request, held until accepted; valid stays up for a back-to-back follower
  task automatic send_axis(input logic [19:0] tm, input logic okm, input logic [19:0] tp,
                           input logic okp, input logic [15:0] spd, input logic lastf,
                           input bit gaps);
    if (gaps) idle_gap();
    s_tdata  <= {6'd0, spd, okp, tp, okm, tm};
    s_tlast  <= lastf;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // well-formed point with 1..3 axes (occasionally 4), random content
  task automatic send_point(input bit gaps);
    int nax;
    logic [19:0] base;
    nax  = ($urandom_range(0, 29) == 0) ? 4 : $urandom_range(1, 3);
    base = $urandom_range(0, 7) == 0 ? 20'($urandom) : 20'($urandom_range(0, 65535));
    for (int k = 0; k < nax; k++)
      send_axis(base + 20'($urandom_range(0, 8192)), ($urandom_range(0, 4) != 0),
                base + 20'($urandom_range(0, 8192)), ($urandom_range(0, 4) != 0),
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1024)),
                k == nax - 1, gaps);
  endtask

  // idle drain, then latency pause, then one register write
  task automatic write_reg(input reg_idx_t idx, input logic [19:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, single-sided neighbours, no neighbour, zero speed
    send_axis(20'd0, 1'b1, 20'd0, 1'b1, 16'd256, 1'b1, 0);
    send_axis(20'hFFFFF, 1'b1, 20'hFFFFF, 1'b1, 16'hFFFF, 1'b1, 0);
    send_axis(20'd100, 1'b0, 20'd5000, 1'b1, 16'd1, 1'b1, 0);
    send_axis(20'd100, 1'b0, 20'd5000, 1'b0, 16'd256, 1'b1, 0);
    send_axis(20'h12345, 1'b1, 20'h00100, 1'b1, 16'd0, 1'b1, 0);
    // 2D point with far-apart times forces the fallback
    send_axis(20'd0, 1'b1, 20'd0, 1'b0, 16'hFFFF, 1'b0, 0);
    send_axis(20'hFFFFF, 1'b1, 20'd0, 1'b0, 16'hFFFF, 1'b1, 0);
    // four axes: saturating axis count
    for (int k = 0; k < 4; k++)
      send_axis(20'h0AAAA, 1'b1, 20'h55555, 1'b1, 16'h5555, k == 3, 0);
    send_axis(20'h55555, 1'b1, 20'h0AAAA, 1'b1, 16'hAAAA, 1'b1, 0);

    write_reg(REG_SPACING0, 20'd1);
    write_reg(REG_SPACING1, 20'hFFFF);
    write_reg(REG_SPACING2, 20'd1);
    write_reg(REG_FALLBACK, 20'hFFFFF);
    send_axis(20'd0, 1'b1, 20'd0, 1'b0, 16'hFFFF, 1'b0, 0);
    send_axis(20'hFFFFF, 1'b1, 20'd0, 1'b0, 16'hFFFF, 1'b1, 0);
    write_reg(REG_FALLBACK, 20'd0);
    send_axis(20'd0, 1'b1, 20'd0, 1'b0, 16'hFFFF, 1'b0, 0);
    send_axis(20'hFFFFF, 1'b1, 20'd0, 1'b0, 16'hFFFF, 1'b1, 0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      write_reg(REG_SPACING0, (ph == 5) ? 20'hFFFF : 20'($urandom_range(1, 1024)));
      write_reg(REG_SPACING1, (ph == 4) ? 20'd1 : 20'($urandom_range(1, 1024)));
      write_reg(REG_SPACING2, 20'($urandom_range(1, 65535)));
      write_reg(REG_FALLBACK, 20'($urandom));
      for (int p = 0; p < 55; p++) begin
        if ($urandom_range(0, 9) == 0)
          send_axis(20'($urandom), 1'($urandom), 20'($urandom), 1'($urandom),
                    16'($urandom), 1'($urandom), 1);
        else send_point(ph != 2);
        if (p == 30) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending_points != 0) @(posedge clk);
        end
      end
    end
    // close any point left open by noise
    send_axis(20'd0, 1'b1, 20'd0, 1'b1, 16'd256, 1'b1, 0);
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (pending_points != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
